[sv/hpsc_pkg.sv]
// Shared types, constants and prefix tables for the payload signature classifier.
package hpsc_pkg;

    localparam int unsigned NUM_METHODS = 9;
    localparam int unsigned NUM_HEADERS = 7;
    // One cell per byte position of the longest prefix.
    localparam int unsigned NUM_CELLS   = 23;
    localparam int unsigned PAT_BITS    = NUM_CELLS * 8;

    typedef logic [7:0]             t_byte;
    typedef logic [NUM_METHODS-1:0] t_meth_mask;
    typedef logic [NUM_HEADERS-1:0] t_hdr_mask;
    typedef logic [4:0]             t_len;
    typedef logic [3:0]             t_meth_idx;
    typedef logic [1:0]             t_class;

    // Line-position token handed from cell to cell.
    typedef struct packed {
        logic       valid;
        t_meth_mask m;
        t_hdr_mask  h;
    } t_tok;

    typedef enum logic [1:0] {
        PH_METHOD,
        PH_HEADER,
        PH_STOPPED
    } t_phase;

    localparam t_tok TOK_NONE  = '0;
    localparam t_tok TOK_START = '{valid: 1'b1, m: {NUM_METHODS{1'b1}}, h: {NUM_HEADERS{1'b1}}};
    localparam t_tok TOK_LINE  = '{valid: 1'b1, m: {NUM_METHODS{1'b0}}, h: {NUM_HEADERS{1'b1}}};

    // Method codes, in priority order (lowest wins).
    localparam t_meth_idx METH_GET_GET    = 4'd0;
    localparam t_meth_idx METH_GET_URI    = 4'd1;
    localparam t_meth_idx METH_GET_HASH   = 4'd2;
    localparam t_meth_idx METH_GET_FILE   = 4'd3;
    localparam t_meth_idx METH_GET_SIG    = 4'd4;
    localparam t_meth_idx METH_GET_POISON = 4'd5;
    localparam t_meth_idx METH_GET_ROOT   = 4'd6;
    localparam t_meth_idx METH_GIVE       = 4'd7;
    localparam t_meth_idx METH_HTTP_RESP  = 4'd8;
    localparam t_meth_idx METH_NONE       = 4'd9;

    // Header flag positions.
    localparam int unsigned HDR_A     = 0;
    localparam int unsigned HDR_B     = 1;
    localparam int unsigned HDR_MSG   = 2;
    localparam int unsigned HDR_ALIAS = 3;
    localparam int unsigned HDR_URN   = 4;
    localparam int unsigned HDR_QUEUE = 5;
    localparam int unsigned HDR_TREE  = 6;

    localparam t_class CLASS_NONE   = 2'd0;
    localparam t_class CLASS_FIRST  = 2'd1;
    localparam t_class CLASS_SECOND = 2'd2;
    localparam t_class CLASS_THIRD  = 2'd3;

    // Prefixes as ASCII, right-aligned, first character in the top byte.
    localparam logic [PAT_BITS-1:0] METH_PAT [NUM_METHODS] = '{
        PAT_BITS'(72'h474554202F6765742F),
        PAT_BITS'(104'h474554202F7572692D7265732F),
        PAT_BITS'(88'h474554202F2E686173683D),
        PAT_BITS'(80'h474554202F2E66696C65),
        PAT_BITS'(72'h474554202F2E736967),
        PAT_BITS'(184'h474554202F506F69736F6E6564446F776E6C6F6164732F),
        PAT_BITS'(40'h474554202F),
        PAT_BITS'(40'h4749564520),
        PAT_BITS'(64'h485454502F312E31)
    };
    localparam t_len METH_LEN [NUM_METHODS] = '{
        5'd9, 5'd13, 5'd11, 5'd10, 5'd9, 5'd23, 5'd5, 5'd5, 5'd8
    };

    localparam logic [PAT_BITS-1:0] HDR_PAT [NUM_HEADERS] = '{
        PAT_BITS'(64'h582D4B617A61612D),
        PAT_BITS'(88'h582D476E7574656C6C612D),
        PAT_BITS'(112'h582D5032502D4D6573736167653A),
        PAT_BITS'(112'h582D4F70656E6674416C6961733A),
        PAT_BITS'(96'h436F6E74656E742D55524E3A),
        PAT_BITS'(64'h582D51756575653A),
        PAT_BITS'(88'h582D546967657254726565)
    };
    localparam t_len HDR_LEN [NUM_HEADERS] = '{
        5'd8, 5'd11, 5'd14, 5'd14, 5'd12, 5'd8, 5'd11
    };

    localparam t_byte CHAR_CR = 8'h0D;
    localparam t_byte CHAR_LF = 8'h0A;

    function automatic t_byte meth_char(int unsigned idx, int unsigned pos);
        logic [PAT_BITS-1:0] v;
        v = '0;
        if (pos < METH_LEN[idx]) begin
            v = METH_PAT[idx] >> (8 * (int'(METH_LEN[idx]) - 1 - int'(pos)));
        end
        return v[7:0];
    endfunction

    function automatic t_byte hdr_char(int unsigned idx, int unsigned pos);
        logic [PAT_BITS-1:0] v;
        v = '0;
        if (pos < HDR_LEN[idx]) begin
            v = HDR_PAT[idx] >> (8 * (int'(HDR_LEN[idx]) - 1 - int'(pos)));
        end
        return v[7:0];
    endfunction

endpackage

[sv/hpsc_if.sv]
// Valid/ready channel interfaces for the classifier's byte input and class output.
interface hpsc_in_if import hpsc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte byte_value;
    logic  last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface hpsc_out_if import hpsc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_class protocol_class;

    modport source (output valid, output protocol_class, input ready);
    modport sink   (input valid, input protocol_class, output ready);
endinterface

[sv/http_payload_signature_classifier.sv]
// Top level of the payload signature classifier: cell chain, phase control, output word.
//
// Usage: payload bytes enter on i_in, one word per byte, with last_byte set on
// the final byte of each payload. For every payload one class word leaves on
// o_out: 0 none, 1..3 one of three protocol families.
// Matching runs in a chain of 23 cells, one per byte position of a line. A
// position token carrying the still-alive prefix masks steps one cell along
// per byte; a line feed restarts it at the first cell. The first line is
// compared with nine method prefixes, later lines with seven header prefixes,
// until a line that begins with CR or LF.
// Throughput: one byte per cycle, back to back, while the output word is not
// held by a stall. The class word is registered and valid in the cycle after
// the last byte is accepted.
// Reset (synchronous, active low) returns the chain to line start, clears
// the found method, the header flags and the output valid flag. After each final
// byte the same state is reloaded, so payloads may follow without a gap.
// Stall: the output holds one word; while it waits with o_out.ready low,
// i_in.ready drops and every byte is held off until the word is taken. A
// word leaving frees the register in the same cycle, so input continues.
module http_payload_signature_classifier import hpsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hpsc_in_if.sink           i_in,
    hpsc_out_if.source        o_out
);

    t_phase     r_phase, n_phase;
    t_meth_idx  r_found, n_found;
    t_hdr_mask  r_seen,  n_seen;
    logic       r_line_start, n_line_start;
    logic       r_out_valid;
    t_class     r_class;

    logic       w_acc;
    logic       w_step;
    logic       w_clear;
    t_tok       w_seed;
    t_class     w_class;
    t_meth_idx  w_cand;
    t_meth_mask w_m_done;
    t_hdr_mask  w_h_done;
    logic       w_is_cr;
    logic       w_is_lf;

    t_tok       w_link   [NUM_CELLS];
    t_tok       w_next   [NUM_CELLS-1];
    t_meth_mask w_m_part [NUM_CELLS];
    t_hdr_mask  w_h_part [NUM_CELLS];

    function automatic t_class classify(t_meth_idx m, t_hdr_mask h);
        t_class c;
        if ((m == METH_GET_HASH || m == METH_HTTP_RESP) && h[HDR_A]) begin
            c = CLASS_FIRST;
        end else if ((m == METH_GET_FILE || m == METH_GET_SIG || m == METH_HTTP_RESP)
                     && h[HDR_MSG]) begin
            c = CLASS_FIRST;
        end else if (m == METH_GIVE) begin
            c = CLASS_FIRST;
        end else if ((m == METH_GET_GET || m == METH_GET_URI || m == METH_HTTP_RESP)
                     && h[HDR_B]) begin
            c = CLASS_SECOND;
        end else if (m == METH_GET_URI && (h[HDR_URN] || h[HDR_QUEUE])) begin
            c = CLASS_SECOND;
        end else if (m == METH_HTTP_RESP && h[HDR_TREE]) begin
            c = CLASS_SECOND;
        end else if ((m == METH_GET_ROOT || m == METH_HTTP_RESP) && h[HDR_ALIAS]) begin
            c = CLASS_THIRD;
        end else if (m == METH_GET_POISON) begin
            c = CLASS_THIRD;
        end else begin
            c = CLASS_NONE;
        end
        return c;
    endfunction

    // Take a byte whenever the output word is free or leaving this cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_is_cr    = (i_in.byte_value == CHAR_CR);
    assign w_is_lf    = (i_in.byte_value == CHAR_LF);

    assign o_out.valid          = r_out_valid;
    assign o_out.protocol_class = r_class;

    // Chain links: a restart empties every cell but the first, which takes the seed.
    always_comb begin
        w_link[0] = w_seed;
        for (int k = 1; k < NUM_CELLS; k++) begin
            w_link[k] = w_clear ? TOK_NONE : w_next[k-1];
        end
    end

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        if (k < NUM_CELLS - 1) begin : g_mid
            hpsc_cell #(.OFFSET(k)) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_step   (w_step),
                .i_byte   (i_in.byte_value),
                .i_prev   (w_link[k]),
                .o_next   (w_next[k]),
                .o_m_done (w_m_part[k]),
                .o_h_done (w_h_part[k])
            );
        end else begin : g_tail
            // Drop the token past the last cell: a longer line matches nothing.
            hpsc_cell #(.OFFSET(k)) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_step   (w_step),
                .i_byte   (i_in.byte_value),
                .i_prev   (w_link[k]),
                .o_next   (),
                .o_m_done (w_m_part[k]),
                .o_h_done (w_h_part[k])
            );
        end
    end

    // Gather completions; only the cell holding the token can report one.
    always_comb begin
        w_m_done = '0;
        w_h_done = '0;
        for (int k = 0; k < NUM_CELLS; k++) begin
            w_m_done = w_m_done | w_m_part[k];
            w_h_done = w_h_done | w_h_part[k];
        end
        w_cand = METH_NONE;
        for (int i = NUM_METHODS - 1; i >= 0; i--) begin
            if (w_m_done[i]) begin
                w_cand = t_meth_idx'(i);
            end
        end
    end

    // Phase control and payload-end handling.
    always_comb begin
        n_phase      = r_phase;
        n_found      = r_found;
        n_seen       = r_seen;
        n_line_start = r_line_start;
        w_step       = 1'b0;
        w_clear      = 1'b0;
        w_seed       = TOK_NONE;
        w_class      = CLASS_NONE;
        if (w_acc) begin
            unique case (r_phase)
                PH_METHOD: begin
                    w_step = 1'b1;
                    if (w_cand < r_found) begin
                        n_found = w_cand;
                    end
                    if (w_is_lf) begin
                        n_phase      = PH_HEADER;
                        w_clear      = 1'b1;
                        w_seed       = TOK_LINE;
                        n_line_start = 1'b1;
                    end else begin
                        n_line_start = 1'b0;
                    end
                end
                PH_HEADER: begin
                    if (r_line_start && (w_is_cr || w_is_lf)) begin
                        // Empty line: end of headers, stop scanning.
                        n_phase = PH_STOPPED;
                    end else begin
                        w_step = 1'b1;
                        n_seen = r_seen | w_h_done;
                        if (w_is_lf) begin
                            w_clear      = 1'b1;
                            w_seed       = TOK_LINE;
                            n_line_start = 1'b1;
                        end else begin
                            n_line_start = 1'b0;
                        end
                    end
                end
                PH_STOPPED: begin
                    n_phase = PH_STOPPED;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
            if (i_in.last_byte) begin
                // Classify on this byte's results, then reload for the next payload.
                w_class      = classify(n_found, n_seen);
                w_step       = 1'b1;
                w_clear      = 1'b1;
                w_seed       = TOK_START;
                n_phase      = PH_METHOD;
                n_found      = METH_NONE;
                n_seen       = '0;
                n_line_start = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_METHOD;
            r_found      <= METH_NONE;
            r_seen       <= '0;
            r_line_start <= 1'b1;
        end else begin
            r_phase      <= n_phase;
            r_found      <= n_found;
            r_seen       <= n_seen;
            r_line_start <= n_line_start;
        end
    end

    // Output word: load on a final byte, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc && i_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.last_byte) begin
            r_class <= w_class;
        end
    end

endmodule

[sv/hpsc_cell.sv]
// One byte-position cell of the prefix matching chain.
module hpsc_cell import hpsc_pkg::*; #(
    parameter int unsigned OFFSET = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_byte      i_byte,
    input  t_tok       i_prev,
    output t_tok       o_next,
    output t_meth_mask o_m_done,
    output t_hdr_mask  o_h_done
);

    t_tok r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= (OFFSET == 0) ? TOK_START : TOK_NONE;
        end else if (i_step) begin
            r_tok <= i_prev;
        end
    end

    // Compare the byte against each prefix character at this position.
    always_comb begin
        logic hit;
        logic fin;
        o_next       = TOK_NONE;
        o_next.valid = r_tok.valid;
        o_m_done     = '0;
        o_h_done     = '0;
        for (int i = 0; i < NUM_METHODS; i++) begin
            hit = r_tok.valid && r_tok.m[i] && (OFFSET < METH_LEN[i])
                  && (i_byte == meth_char(i, OFFSET));
            fin = (OFFSET + 1 == METH_LEN[i]);
            o_m_done[i] = hit && fin;
            o_next.m[i] = hit && !fin;
        end
        for (int j = 0; j < NUM_HEADERS; j++) begin
            hit = r_tok.valid && r_tok.h[j] && (OFFSET < HDR_LEN[j])
                  && (i_byte == hdr_char(j, OFFSET));
            fin = (OFFSET + 1 == HDR_LEN[j]);
            o_h_done[j] = hit && fin;
            o_next.h[j] = hit && !fin;
        end
    end

endmodule

[sv/hpsc_checker.sv]
// Port-level checks for the payload signature classifier, bound to the top level.
module hpsc_checker import hpsc_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_in_last,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_class i_out_class
);

    // A stalled class word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_class)))
        else $error("class word changed or vanished while stalled");

    // A final byte yields a class word in the next cycle.
    a_last_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_last) |=> i_out_valid)
        else $error("no class word after final byte");

    // A new class word only follows an accepted final byte.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last))
        else $error("class word without a final byte");

    // With the output empty, input is never held off.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

endmodule

bind http_payload_signature_classifier hpsc_checker u_hpsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last_byte),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_class (o_out.protocol_class)
);

[verif/http_payload_signature_classifier_test.sv]
// Self-checking testbench for the payload signature classifier: directed and random payloads.
module http_payload_signature_classifier_test;
    import hpsc_pkg::*;

    // Stop the run here if it has not ended by itself; sized well beyond the slowest run.
    localparam int unsigned CYCLE_LIMIT   = 200000;
    // Receiver hold-off: start cycle and length, long enough to back the input up.
    localparam int unsigned HOLD_AT       = 1500;
    localparam int unsigned HOLD_LEN      = 300;
    localparam int unsigned BYTE_TARGET   = 1250;
    localparam int unsigned PAYLOAD_FLOOR = 60;
    localparam int unsigned TAIL_CYCLES   = 8;
    localparam int unsigned REPORT_CAP    = 50;

    // One planned input word, or a marker that makes the sender wait for all results.
    typedef struct {
        t_byte       value;
        bit          fin;
        int unsigned gap;
        bit          drain;
    } t_byte_slot;

    logic i_clk = 1'b0;
    logic i_rst_n;

    hpsc_in_if  in_ch ();
    hpsc_out_if out_ch ();

    http_payload_signature_classifier dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Method prefixes in priority order; header prefixes left-aligned, first byte on top.
    string meth_txt [NUM_METHODS] = '{
        "GET /get/", "GET /uri-res/", "GET /.hash=", "GET /.file", "GET /.sig",
        "GET /PoisonedDownloads/", "GET /", "GIVE ", "HTTP/1.1"
    };
    localparam logic [111:0] HDR_TXT [NUM_HEADERS] = '{
        112'h582D4B617A61612D_000000000000,
        112'h582D476E7574656C6C612D_000000,
        112'h582D5032502D4D6573736167653A,
        112'h582D4F70656E6674416C6961733A,
        112'h436F6E74656E742D55524E3A_0000,
        112'h582D51756575653A_000000000000,
        112'h582D546967657254726565_000000
    };
    localparam int unsigned HDR_SIZE [NUM_HEADERS] = '{8, 11, 14, 14, 12, 8, 11};

    t_byte_slot  byte_plan [$];
    t_byte       draft [$];
    t_class      class_due [$];
    int unsigned classes_owed;
    int unsigned faults;
    int unsigned bytes_planned;
    int unsigned payloads_planned;
    int unsigned bytes_taken;
    int unsigned classes_checked;
    int unsigned class_hist [4];
    int unsigned cycle_count;

    // Classifier state as this bench tracks it.
    t_meth_mask  meth_live;
    t_meth_idx   meth_hit;
    logic [4:0]  col;
    t_hdr_mask   hdr_live;
    t_hdr_mask   hdr_hits;
    t_phase      phase;

    int unsigned send_wait;
    int unsigned rx_cycles;
    int unsigned rx_stall;
    int unsigned rx_calm;

    function automatic t_byte hdr_byte(int unsigned idx, int unsigned pos);
        return HDR_TXT[idx][111 - 8 * pos -: 8];
    endfunction

    function automatic void restart_payload();
        meth_live = '1;
        meth_hit  = METH_NONE;
        col       = '0;
        hdr_live  = '1;
        hdr_hits  = '0;
        phase     = PH_METHOD;
    endfunction

    // Ordered family rules; a method match is needed for anything but none.
    function automatic t_class family_of(t_meth_idx m, t_hdr_mask h);
        if ((m == METH_GET_HASH || m == METH_HTTP_RESP) && h[HDR_A]) return CLASS_FIRST;
        if ((m == METH_GET_FILE || m == METH_GET_SIG || m == METH_HTTP_RESP) && h[HDR_MSG])
            return CLASS_FIRST;
        if (m == METH_GIVE) return CLASS_FIRST;
        if ((m == METH_GET_GET || m == METH_GET_URI || m == METH_HTTP_RESP) && h[HDR_B])
            return CLASS_SECOND;
        if (m == METH_GET_URI && (h[HDR_URN] || h[HDR_QUEUE])) return CLASS_SECOND;
        if (m == METH_HTTP_RESP && h[HDR_TREE]) return CLASS_SECOND;
        if ((m == METH_GET_ROOT || m == METH_HTTP_RESP) && h[HDR_ALIAS]) return CLASS_THIRD;
        if (m == METH_GET_POISON) return CLASS_THIRD;
        return CLASS_NONE;
    endfunction

    // Absorb one accepted word; return 1 with the class when it closes the payload.
    function automatic bit absorb_byte(input t_byte b, input bit fin, output t_class cls);
        int unsigned pos;
        pos = col;
        cls = CLASS_NONE;
        case (phase)
            PH_METHOD: begin
                for (int i = 0; i < NUM_METHODS; i++) begin
                    if (meth_live[i]) begin
                        if (pos < meth_txt[i].len() && b == t_byte'(meth_txt[i][pos])) begin
                            if (pos + 1 == meth_txt[i].len()) begin
                                if (i < meth_hit) meth_hit = t_meth_idx'(i);
                                meth_live[i] = 1'b0;
                            end
                        end else begin
                            meth_live[i] = 1'b0;
                        end
                    end
                end
                if (b == CHAR_LF) begin
                    phase    = PH_HEADER;
                    col      = '0;
                    hdr_live = '1;
                end else if (col != 5'd31) begin
                    col = col + 5'd1;
                end
            end
            PH_HEADER: begin
                // An empty line ends the header block for good.
                if (pos == 0 && (b == CHAR_CR || b == CHAR_LF)) begin
                    phase = PH_STOPPED;
                end else begin
                    for (int i = 0; i < NUM_HEADERS; i++) begin
                        if (hdr_live[i]) begin
                            if (pos < HDR_SIZE[i] && b == hdr_byte(i, pos)) begin
                                if (pos + 1 == HDR_SIZE[i]) begin
                                    hdr_hits[i] = 1'b1;
                                    hdr_live[i] = 1'b0;
                                end
                            end else begin
                                hdr_live[i] = 1'b0;
                            end
                        end
                    end
                    if (b == CHAR_LF) begin
                        col      = '0;
                        hdr_live = '1;
                    end else if (col != 5'd31) begin
                        col = col + 5'd1;
                    end
                end
            end
            default: ;
        endcase
        if (fin) begin
            cls = family_of(meth_hit, hdr_hits);
            restart_payload();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------- stimulus plan

    function automatic t_byte noise_byte();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return CHAR_CR;
        if (r == 1) return CHAR_LF;
        return t_byte'($urandom_range(0, 255));
    endfunction

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic append_byte(t_byte b);
        draft.push_back(b);
    endtask

    task automatic append_text(string s);
        for (int k = 0; k < s.len(); k++) append_byte(t_byte'(s[k]));
    endtask

    task automatic append_hdr_part(int unsigned idx, int unsigned n);
        for (int unsigned k = 0; k < n; k++) append_byte(hdr_byte(idx, k));
    endtask

    task automatic append_hdr(int unsigned idx);
        append_hdr_part(idx, HDR_SIZE[idx]);
    endtask

    task automatic append_break();
        if ($urandom_range(0, 3) != 0) append_byte(CHAR_CR);
        append_byte(CHAR_LF);
    endtask

    // Move the draft into the send plan, last word marked; some payloads go without gaps.
    task automatic ship_payload();
        bit          calm;
        t_byte_slot  s;
        calm = ($urandom_range(0, 3) == 0);
        foreach (draft[k]) begin
            s.value = draft[k];
            s.fin   = (k == draft.size() - 1);
            s.gap   = calm ? 0 : pick_gap();
            s.drain = 1'b0;
            byte_plan.push_back(s);
        end
        bytes_planned    += draft.size();
        payloads_planned += 1;
        draft.delete();
    endtask

    task automatic plan_drain();
        t_byte_slot s;
        s = '{value: '0, fin: 1'b0, gap: 0, drain: 1'b1};
        byte_plan.push_back(s);
    endtask

    // Mostly well-formed requests with random content; the rest noise and broken lines.
    task automatic build_random_payload();
        int unsigned m;
        int unsigned cut;
        int unsigned lines;
        int unsigned r;
        int unsigned h;
        if ($urandom_range(0, 99) < 35) begin
            repeat ($urandom_range(1, 8)) append_byte(noise_byte());
            return;
        end
        m   = $urandom_range(0, NUM_METHODS - 1);
        cut = meth_txt[m].len();
        if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, cut - 1);
        for (int k = 0; k < cut; k++) append_byte(t_byte'(meth_txt[m][k]));
        if ($urandom_range(0, 9) == 0) draft[$urandom_range(0, draft.size() - 1)] = noise_byte();
        if ($urandom_range(0, 7) == 0) return;
        repeat ($urandom_range(0, 3)) append_byte(t_byte'($urandom_range(33, 126)));
        append_break();
        lines = $urandom_range(0, 2);
        for (int unsigned n = 0; n < lines; n++) begin
            r = $urandom_range(0, 99);
            h = $urandom_range(0, NUM_HEADERS - 1);
            if (r < 65) begin
                if ($urandom_range(0, 9) == 0) append_hdr_part(h, $urandom_range(1, HDR_SIZE[h] - 1));
                else append_hdr(h);
                if ($urandom_range(0, 7) == 0) return;
                repeat ($urandom_range(0, 3)) append_byte(t_byte'($urandom_range(32, 126)));
            end else if (r < 80) begin
                repeat ($urandom_range(0, 4)) append_byte(noise_byte());
            end else if (r < 90) begin
                repeat ($urandom_range(28, 36)) append_byte(t_byte'($urandom_range(32, 126)));
            end else begin
                append_byte(t_byte'($urandom_range(32, 126)));
                append_hdr(h);
            end
            append_break();
        end
        if ($urandom_range(0, 3) == 0) begin
            append_break();
            repeat ($urandom_range(0, 4)) append_byte(noise_byte());
        end
    endtask

    task automatic build_directed();
        // single-byte payloads at the byte extremes
        append_byte(8'h00); ship_payload();
        append_byte(8'hFF); ship_payload();
        // leading CR or LF matches no method
        append_byte(CHAR_CR); ship_payload();
        append_text("\nGET /"); ship_payload();
        // prefix ending exactly on the final word, and one cut short
        append_text("GIVE "); ship_payload();
        append_text("GIVE"); ship_payload();
        append_text("GET /PoisonedDownloads/"); ship_payload();
        append_text("GET /\n"); append_hdr(HDR_ALIAS); ship_payload();
        append_text("GET /.hash=\n"); append_hdr(HDR_A); ship_payload();
        append_text("GET /.file\r\n"); append_hdr(HDR_MSG); ship_payload();
        append_text("GET /.sig\r\n"); append_hdr_part(HDR_MSG, HDR_SIZE[HDR_MSG] - 1);
        ship_payload();
        append_text("GET /get/\n"); append_hdr(HDR_B); ship_payload();
        append_text("GET /uri-res/\r\n"); append_hdr(HDR_URN); ship_payload();
        append_text("GET /uri-res/\r\n"); append_hdr(HDR_QUEUE); append_text(" 1\r\n\r\n");
        ship_payload();
        append_text("HTTP/1.1\r\n"); append_hdr(HDR_TREE); ship_payload();
        // empty line stops the header scan before a matching header
        append_text("HTTP/1.1\r\n\r\n"); append_hdr(HDR_A); ship_payload();
        // final LF after a header
        append_text("HTTP/1.1\n"); append_hdr(HDR_A); append_byte(CHAR_LF); ship_payload();
        // header text not at line start
        append_text("HTTP/1.1\nab"); append_hdr(HDR_A); ship_payload();
        // headers without a method
        append_text("junk\n"); append_hdr(HDR_A); ship_payload();
        // long lines saturate the line offset
        append_text("GET /"); repeat (34) append_byte(t_byte'("a"));
        append_text("\r\n"); append_hdr(HDR_ALIAS); ship_payload();
        append_text("HTTP/1.1\n"); repeat (40) append_byte(t_byte'("z"));
        append_byte(CHAR_LF); append_hdr(HDR_A); ship_payload();
    endtask

    // ---------------------------------------------------------------- driver

    // Offer the next planned word once the current one is taken; hold a drain
    // marker until nothing is owed and no word is on the bus.
    always @(posedge i_clk) begin
        t_byte_slot nxt;
        if (!i_rst_n) begin
            in_ch.valid      <= 1'b0;
            in_ch.byte_value <= '0;
            in_ch.last_byte  <= 1'b0;
            send_wait        <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (send_wait != 0) begin
                in_ch.valid <= 1'b0;
                send_wait   <= send_wait - 1;
            end else if (byte_plan.size() != 0 && byte_plan[0].drain) begin
                in_ch.valid <= 1'b0;
                if (!in_ch.valid && classes_owed == 0) void'(byte_plan.pop_front());
            end else if (byte_plan.size() != 0) begin
                nxt = byte_plan.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.byte_value <= nxt.value;
                in_ch.last_byte  <= nxt.fin;
                send_wait        <= nxt.gap;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // Random stalls, calm stretches, and one long hold-off counted here.
    always @(posedge i_clk) begin
        int unsigned r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_cycles    <= 0;
            rx_stall     <= 0;
            rx_calm      <= 0;
        end else begin
            rx_cycles <= rx_cycles + 1;
            r = $urandom_range(0, 99);
            if (rx_cycles == HOLD_AT) begin
                out_ch.ready <= 1'b0;
                rx_stall     <= HOLD_LEN;
            end else if (rx_stall != 0) begin
                out_ch.ready <= 1'b0;
                rx_stall     <= rx_stall - 1;
            end else if (rx_calm != 0) begin
                out_ch.ready <= 1'b1;
                rx_calm      <= rx_calm - 1;
            end else if (r < 5) begin
                out_ch.ready <= 1'b1;
                rx_calm      <= $urandom_range(20, 150);
            end else if (r < 8) begin
                out_ch.ready <= 1'b0;
                rx_stall     <= $urandom_range(10, 40);
            end else if (r < 30) begin
                out_ch.ready <= 1'b0;
                rx_stall     <= $urandom_range(0, 2);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    // Check each class word against the oldest expectation, then predict from
    // the input word taken on the same edge.
    always @(posedge i_clk) begin
        t_class cls;
        t_class want;
        if (!i_rst_n) begin
            restart_payload();
            classes_owed <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (class_due.size() == 0) begin
                    faults++;
                    if (faults <= REPORT_CAP)
                        $display("%0t: unexpected class word, expected none, got %0d",
                                 $time, out_ch.protocol_class);
                end else begin
                    want = class_due.pop_front();
                    if (out_ch.protocol_class !== want) begin
                        faults++;
                        if (faults <= REPORT_CAP)
                            $display("%0t: protocol_class mismatch, expected %0d, got %0d",
                                     $time, want, out_ch.protocol_class);
                    end
                    class_hist[want]++;
                end
                classes_checked++;
            end
            if (in_ch.valid && in_ch.ready) begin
                bytes_taken++;
                if (absorb_byte(in_ch.byte_value, in_ch.last_byte, cls)) class_due.push_back(cls);
            end
            classes_owed <= class_due.size();
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d class words still owed", $time, class_due.size());
            $display("** http_payload_signature_classifier: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.byte_value = '0;
        in_ch.last_byte  = 1'b0;
        out_ch.ready     = 1'b0;
        i_rst_n          = 1'b0;
        faults           = 0;
        cycle_count      = 0;
        bytes_planned    = 0;
        payloads_planned = 0;
        bytes_taken      = 0;
        classes_checked  = 0;
        class_hist       = '{default: 0};
        restart_payload();

        // Build the whole plan up front; the driver drains it.
        build_directed();
        plan_drain();
        for (int unsigned n = 0; bytes_planned < BYTE_TARGET || n < PAYLOAD_FLOOR; n++) begin
            build_random_payload();
            ship_payload();
            if (n == 30) plan_drain();
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the plan to empty and every class word to arrive, then linger.
        while (byte_plan.size() != 0 || in_ch.valid || classes_owed != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (class_due.size() != 0) begin
            faults++;
            $display("%0t: %0d class words never arrived", $time, class_due.size());
        end
        $display("Run: %0d payloads, %0d bytes accepted, %0d class words checked",
                 payloads_planned, bytes_taken, classes_checked);
        $display("Classes seen: none %0d, first %0d, second %0d, third %0d",
                 class_hist[CLASS_NONE], class_hist[CLASS_FIRST],
                 class_hist[CLASS_SECOND], class_hist[CLASS_THIRD]);
        if (faults == 0) begin
            $display("** http_payload_signature_classifier: PASSED **");
        end else begin
            $display("** http_payload_signature_classifier: FAILED **");
        end
        $finish;
    end

endmodule
